// File: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: request and
// response payloads, operation and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // default arena geometry
   localparam int ARENA_BYTES_DEF  = 4096;
   localparam int HEADER_BYTES_DEF = 28;
   localparam int MAX_BLOCKS_DEF   = 256;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] ST_GRANTED   = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_FREED     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic        op;
      logic [15:0] req_size;
      logic [11:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [11:0] addr;
      logic [1:0]  status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // capture request, read chain head
      logic next;       // read the block linked after the current one
      logic latch_hit;  // current block matches: capture it and the result
      logic latch_miss; // chain ended without a match
      logic wr_cur;     // write back the matched block
      logic wr_new;     // write the split-off remainder block
      logic load_rsp;   // move the result into the response register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // current block satisfies the request
      logic has_next;   // current block links to another block
      logic split;      // captured match gets split
   } dp_status_type;

endpackage

// File: rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, chain walker read port, fit/match compare, split
// arithmetic and the result and response registers.
// ----------------------------------------------------------------------------
module ffba_datapath #(
   parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffba_pkg::req_type      req_data,
   input  ffba_pkg::ctl_cmd_type  cmd,
   output ffba_pkg::dp_status_type status,
   output ffba_pkg::rsp_type      rsp_data
);

   localparam int OFF_W  = $clog2(ARENA_BYTES);
   localparam int LINK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W  = ((OFF_W > 16) ? OFF_W : 16) + 2;

   typedef struct packed {
      logic              free;
      logic              has_link;
      logic [LINK_W-1:0] link;
      logic [OFF_W-1:0]  size;
      logic [OFF_W-1:0]  offset;
   } rec_type;

   localparam rec_type INIT_REC = '{
      free:     1'b1,
      has_link: 1'b0,
      link:     '0,
      size:     OFF_W'(ARENA_BYTES - HEADER_BYTES),
      offset:   OFF_W'(HEADER_BYTES)
   };

   rec_type           blk_mem [MAX_BLOCKS];
   rec_type           rdata_ff;
   logic [LINK_W-1:0] rd_idx_ff;
   logic              head_fresh_ff;
   logic [CNT_W-1:0]  count_ff;
   ffba_pkg::req_type req_ff;
   rec_type           hit_rec_ff;
   logic [LINK_W-1:0] hit_idx_ff;
   logic              split_ff;
   logic [11:0]       res_addr_ff;
   logic [1:0]        res_status_ff;
   ffba_pkg::rsp_type rsp_ff;

   rec_type           cur;
   logic              rd_en;
   logic [LINK_W-1:0] rd_addr;
   logic              wr_en;
   logic [LINK_W-1:0] wr_addr;
   rec_type           wr_data;
   logic [CMP_W-1:0]  size_ext;
   logic [CMP_W-1:0]  off_ext;
   logic [CMP_W-1:0]  req_ext;
   logic [CMP_W-1:0]  addr_ext;
   logic [CMP_W-1:0]  hdr_ext;
   logic [CMP_W-1:0]  hit_size_ext;
   logic [CMP_W-1:0]  hit_off_ext;
   logic              alloc_hit;
   logic              free_hit;
   logic              split;
   logic [LINK_W-1:0] new_idx;

   // chain head reads as its reset record until first written
   assign cur = (rd_idx_ff == '0 && head_fresh_ff) ? INIT_REC : rdata_ff;

   assign size_ext = CMP_W'(cur.size);
   assign off_ext  = CMP_W'(cur.offset);
   assign req_ext  = CMP_W'(req_ff.req_size);
   assign addr_ext = CMP_W'(req_ff.free_addr);
   assign hdr_ext  = CMP_W'(HEADER_BYTES);

   assign alloc_hit = cur.free && (size_ext >= req_ext);
   assign free_hit  = (off_ext == addr_ext);
   assign split     = (size_ext > req_ext + hdr_ext) && (count_ff < CNT_W'(MAX_BLOCKS));

   assign status.hit      = (req_ff.op == ffba_pkg::OP_ALLOC) ? alloc_hit : free_hit;
   assign status.has_next = cur.has_link &&
                            ((LINK_W + 1)'(cur.link) < (LINK_W + 1)'(MAX_BLOCKS));
   assign status.split    = split_ff;

   // walk the chain: head on accept, then follow the link
   assign rd_en   = cmd.accept || cmd.next;
   assign rd_addr = cmd.accept ? '0 : cur.link;

   assign new_idx      = count_ff[LINK_W-1:0];
   assign hit_size_ext = CMP_W'(hit_rec_ff.size);
   assign hit_off_ext  = CMP_W'(hit_rec_ff.offset);

   // build the write-back record
   always_comb begin
      wr_en   = cmd.wr_cur || cmd.wr_new;
      wr_addr = hit_idx_ff;
      wr_data = hit_rec_ff;
      if (cmd.wr_new) begin
         wr_addr          = new_idx;
         wr_data.free     = 1'b1;
         wr_data.has_link = hit_rec_ff.has_link;
         wr_data.link     = hit_rec_ff.link;
         wr_data.offset   = OFF_W'(hit_off_ext + req_ext + hdr_ext);
         wr_data.size     = OFF_W'(hit_size_ext - req_ext - hdr_ext);
      end else if (req_ff.op == ffba_pkg::OP_FREE) begin
         wr_data.free = 1'b1;
      end else begin
         wr_data.free = 1'b0;
         if (split_ff) begin
            wr_data.size     = OFF_W'(req_ext);
            wr_data.link     = new_idx;
            wr_data.has_link = 1'b1;
         end
      end
   end

   // block table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff  <= blk_mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   // head override flag and block count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_fresh_ff <= 1'b1;
         count_ff      <= CNT_W'(1);
      end else begin
         if (wr_en && wr_addr == '0) begin
            head_fresh_ff <= 1'b0;
         end
         if (cmd.wr_new) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // capture request, match and result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.latch_hit) begin
         hit_rec_ff <= cur;
         hit_idx_ff <= rd_idx_ff;
         split_ff   <= (req_ff.op == ffba_pkg::OP_ALLOC) && split;
         if (req_ff.op == ffba_pkg::OP_ALLOC) begin
            res_addr_ff   <= off_ext[11:0];
            res_status_ff <= ffba_pkg::ST_GRANTED;
         end else begin
            res_addr_ff   <= '0;
            res_status_ff <= ffba_pkg::ST_FREED;
         end
      end
      if (cmd.latch_miss) begin
         res_addr_ff   <= '0;
         res_status_ff <= (req_ff.op == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NO_FIT
                                                             : ffba_pkg::ST_NOT_FOUND;
      end
      if (cmd.load_rsp) begin
         rsp_ff.addr   <= res_addr_ff;
         rsp_ff.status <= res_status_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: accept, walk the chain, write back, hand off response.
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ffba_pkg::dp_status_type status,
   output ffba_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WR_CUR,
      S_WR_NEW,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.hit) begin
               cmd.latch_hit = 1'b1;
               state_in      = S_WR_CUR;
            end else if (status.has_next) begin
               cmd.next = 1'b1;
            end else begin
               cmd.latch_miss = 1'b1;
               state_in       = S_RESP;
            end
         end
         S_WR_CUR: begin
            cmd.wr_cur = 1'b1;
            state_in   = status.split ? S_WR_NEW : S_RESP;
         end
         S_WR_NEW: begin
            cmd.wr_new = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/first_fit_block_allocator.sv
// Sequence: acceptance reads the chain head; chain blocks are then visited one per cycle,
//   through the block table read port, until a match or the chain end; a match writes
//   back the matched block and, on a split, the remainder block. The result enters the
//   response register once the response slot is free. One transaction at a time: the next
//   request is taken in the cycle after the result enters the response register.
// Reset: one free block spans the arena; no clearing pass, usable at once.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit arena allocator with block splitting: walks an address-ordered
// block chain to grant or release payload offsets.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffba_pkg::rsp_type rsp_data
);

   ffba_pkg::ctl_cmd_type   cmd;
   ffba_pkg::dp_status_type status;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffba_datapath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: sim/first_fit_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test
// Self-checking bench for the first-fit block allocator. A clocked driver
// sends allocate and free requests from a backlog. A clocked monitor predicts
// each accepted request against a private copy of the block chain and checks
// every response against the oldest prediction. Both sides idle at random,
// phase by phase.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test;

   localparam int ARENA        = ffba_pkg::ARENA_BYTES_DEF;
   localparam int HDR          = ffba_pkg::HEADER_BYTES_DEF;
   localparam int MAXB         = ffba_pkg::MAX_BLOCKS_DEF;
   localparam int PHASE_ITEMS  = 240;
   localparam int LONG_STALL   = 400;
   localparam int SETTLE_CYCLES = 400;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ffba_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ffba_pkg::rsp_type rsp_data;

   // stimulus and scoreboard
   ffba_pkg::req_type req_backlog[$];
   ffba_pkg::rsp_type expected_rsps[$];
   logic [11:0]       live_addrs[$];
   int                mismatch_count = 0;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   logic              long_stall_go  = 1'b0;
   int                stall_left;

   // private copy of the block chain
   logic [11:0] seg_offset [MAXB];
   logic [11:0] seg_size   [MAXB];
   logic        seg_free   [MAXB];
   logic [7:0]  seg_next   [MAXB];
   logic        seg_linked [MAXB];
   int          seg_count;

   first_fit_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Arena after reset: one free block covering everything past one header.
   function automatic void reset_arena();
      for (int i = 0; i < MAXB; i++) begin
         seg_offset[i] = '0;
         seg_size[i]   = '0;
         seg_free[i]   = 1'b0;
         seg_next[i]   = '0;
         seg_linked[i] = 1'b0;
      end
      seg_offset[0] = 12'(HDR);
      seg_size[0]   = 12'(ARENA - HDR);
      seg_free[0]   = 1'b1;
      seg_count     = 1;
   endfunction

   // First free block large enough wins; split off the rest if it exceeds a header and the table has room.
   function automatic ffba_pkg::rsp_type predict_allocate(input logic [15:0] want);
      int                cur;
      int                steps;
      int                c;
      int                fresh;
      ffba_pkg::rsp_type res;
      res.addr   = '0;
      res.status = ffba_pkg::ST_NO_FIT;
      cur   = 0;
      steps = 0;
      while (cur >= 0 && steps < MAXB) begin
         c = cur;
         if (seg_free[c] && int'(seg_size[c]) >= int'(want)) begin
            seg_free[c] = 1'b0;
            if (int'(seg_size[c]) > int'(want) + HDR && seg_count < MAXB) begin
               fresh = seg_count;
               seg_offset[fresh] = 12'(int'(seg_offset[c]) + int'(want) + HDR);
               seg_size[fresh]   = 12'(int'(seg_size[c]) - int'(want) - HDR);
               seg_free[fresh]   = 1'b1;
               seg_next[fresh]   = seg_next[c];
               seg_linked[fresh] = seg_linked[c];
               seg_next[c]       = 8'(fresh);
               seg_linked[c]     = 1'b1;
               seg_size[c]       = 12'(want);
               seg_count         = fresh + 1;
            end
            res.addr   = seg_offset[c];
            res.status = ffba_pkg::ST_GRANTED;
            return res;
         end
         cur = seg_linked[c] ? int'(seg_next[c]) : -1;
         steps++;
      end
      return res;
   endfunction

   // Mark the first block whose payload offset matches as free.
   function automatic ffba_pkg::rsp_type predict_release(input logic [11:0] where);
      int                cur;
      int                steps;
      int                c;
      ffba_pkg::rsp_type res;
      res.addr   = '0;
      res.status = ffba_pkg::ST_NOT_FOUND;
      cur   = 0;
      steps = 0;
      while (cur >= 0 && steps < MAXB) begin
         c = cur;
         if (seg_offset[c] == where) begin
            seg_free[c] = 1'b1;
            res.status  = ffba_pkg::ST_FREED;
            return res;
         end
         cur = seg_linked[c] ? int'(seg_next[c]) : -1;
         steps++;
      end
      return res;
   endfunction

   function automatic ffba_pkg::req_type make_req(input logic op, input int size,
                                                  input int where);
      ffba_pkg::req_type r;
      r.op        = op;
      r.req_size  = 16'(size);
      r.free_addr = 12'(where);
      return r;
   endfunction

   // Mostly frees of live blocks and small allocations, plus some noise.
   function automatic ffba_pkg::req_type random_request();
      int pick;
      int idx;
      logic [11:0] where;
      pick = $urandom_range(99);
      if (live_addrs.size() != 0 && pick < 45) begin
         idx   = $urandom_range(live_addrs.size() - 1);
         where = live_addrs[idx];
         live_addrs.delete(idx);
         return make_req(ffba_pkg::OP_FREE, $urandom_range(65535), where);
      end
      if (pick < 55)
         return make_req(ffba_pkg::OP_FREE, $urandom_range(65535), $urandom_range(4095));
      pick = $urandom_range(99);
      if (pick < 70)
         return make_req(ffba_pkg::OP_ALLOC, $urandom_range(120), $urandom_range(4095));
      if (pick < 85)
         return make_req(ffba_pkg::OP_ALLOC, $urandom_range(1500, 121),
                         $urandom_range(4095));
      if (pick < 95)
         return make_req(ffba_pkg::OP_ALLOC, $urandom_range(4095, 1501),
                         $urandom_range(4095));
      return make_req(ffba_pkg::OP_ALLOC, $urandom_range(65535), $urandom_range(4095));
   endfunction

   // Hold until nothing is queued, offered or awaited.
   task automatic wait_quiet();
      while (req_backlog.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   // Keep the backlog short so frees pick from fresh grants.
   task automatic run_random(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         @(negedge clock);
         if (req_backlog.size() < 2) begin
            req_backlog.push_back(random_request());
            sent++;
         end
      end
   endtask

   // Driver: offer the next backlog item once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: long hold on request, random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (long_stall_go) begin
         rsp_ready  <= 1'b0;
         stall_left <= LONG_STALL;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict accepted requests, check delivered responses.
   always @(posedge clock) begin
      ffba_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_data.op == ffba_pkg::OP_ALLOC)
               expected_rsps.push_back(predict_allocate(req_data.req_size));
            else
               expected_rsps.push_back(predict_release(req_data.free_addr));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: addr %0d status %0d",
                      rsp_data.addr, rsp_data.status);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.addr !== want.addr) begin
                  $error("addr: expected %0d, got %0d", want.addr, rsp_data.addr);
                  mismatch_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (want.status == ffba_pkg::ST_GRANTED)
                  live_addrs.push_back(want.addr);
            end
         end
      end
   end

   initial begin
      reset_arena();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, exact fit, split to a one-byte tail, double free
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 65535, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, ARENA - HDR + 1, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 0, 4095));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, HDR));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 65535, HDR));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 4095));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 0, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 4012, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 0, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 2 * HDR));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 4011, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 1, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 2, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 4095));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 2 * HDR));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, HDR));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, ARENA - 2 * HDR, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_ALLOC, 4011, 0));
      req_backlog.push_back(make_req(ffba_pkg::OP_FREE, 0, 2 * HDR));
      wait_quiet();
      live_addrs.delete();

      // no idling on either side
      run_random(PHASE_ITEMS);
      wait_quiet();

      // receiver holds off long while the sender keeps offering
      long_stall_go = 1'b1;
      @(negedge clock);
      long_stall_go = 1'b0;
      repeat (10) req_backlog.push_back(random_request());
      wait_quiet();

      send_idle_pct = 50;
      run_random(PHASE_ITEMS);
      wait_quiet();

      send_idle_pct  = 0;
      recv_stall_pct = 50;
      run_random(PHASE_ITEMS);
      wait_quiet();

      send_idle_pct  = 23;
      recv_stall_pct = 23;
      run_random(PHASE_ITEMS);
      wait_quiet();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("first_fit_block_allocator_test: PASS");
      else
         $display("first_fit_block_allocator_test: FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #(50_000_000);
      $display("first_fit_block_allocator_test: FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/ffba_pkg.sv
rtl/ffba_datapath.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
sim/first_fit_block_allocator_test.sv
